// File: rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the RPN stack machine: instruction codes,
// error codes, field widths and the request to the multiply/divide unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Fixed widths of the port fields
  localparam int unsigned OPCODE_W  = 4;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned DEPTH_F_W = 9;
  localparam int unsigned ERROR_W   = 2;

  // Instruction codes; the remaining codes act as noop
  typedef enum logic [OPCODE_W-1:0] {
    OP_NOOP = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_MOD  = 4'd5,
    OP_SHL  = 4'd6,
    OP_SAR  = 4'd7,
    OP_AND  = 4'd8,
    OP_OR   = 4'd9,
    OP_XOR  = 4'd10,
    OP_NOT  = 4'd11,
    OP_PUSH = 4'd12
  } op_e;

  // Sticky error codes
  typedef enum logic [ERROR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_DIVZERO   = 2'd3
  } err_e;

  // Operation of the iterative multiply/divide unit
  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

endpackage

// File: rtl/core/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Combinational operations of the stack machine: add, sub, shifts and the
// bitwise operations on the second (x) and top (y) stack entries.
// ----------------------------------------------------------------------------
module rpn_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [rpn_pkg::OPCODE_W-1:0] op_i,
  input  logic [DATA_WIDTH-1:0]        x_i,
  input  logic [DATA_WIDTH-1:0]        y_i,
  output logic [DATA_WIDTH-1:0]        res_o
);

  localparam int unsigned SW = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] WidthVal = DATA_WIDTH'(DATA_WIDTH);

  logic          big_shift;
  logic [SW-1:0] shamt;

  // Shift amount is unsigned; a full-width shift saturates
  assign big_shift = (y_i >= WidthVal);
  assign shamt     = y_i[SW-1:0];

  // Decode operation
  always_comb begin
    unique case (op_i)
      rpn_pkg::OP_ADD: res_o = x_i + y_i;
      rpn_pkg::OP_SUB: res_o = x_i - y_i;
      rpn_pkg::OP_SHL: res_o = big_shift ? '0 : (x_i << shamt);
      rpn_pkg::OP_SAR: res_o = big_shift ? {DATA_WIDTH{x_i[DATA_WIDTH-1]}}
                                         : DATA_WIDTH'($signed(x_i) >>> shamt);
      rpn_pkg::OP_AND: res_o = x_i & y_i;
      rpn_pkg::OP_OR:  res_o = x_i | y_i;
      rpn_pkg::OP_XOR: res_o = x_i ^ y_i;
      default:         res_o = '0;
    endcase
  end

endmodule

// File: rtl/core/rpn_muldiv.sv
// ----------------------------------------------------------------------------
// rpn_muldiv
// Iterative multiply and signed divide/modulo, one bit per cycle.
// Multiply is shift-and-add; divide is restoring division on magnitudes.
// ----------------------------------------------------------------------------
module rpn_muldiv #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rpn_pkg::md_req_t        req_i,
  input  logic [DATA_WIDTH-1:0]   x_i,
  input  logic [DATA_WIDTH-1:0]   y_i,
  output logic                    done_o,
  output logic [DATA_WIDTH-1:0]   res_o
);

  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

  logic                   busy_q;
  logic                   done_q;
  logic [CW-1:0]          cnt_q;
  rpn_pkg::md_op_e        op_q;
  logic                   neg_q;
  logic [DATA_WIDTH:0]    acc_q;
  logic [DATA_WIDTH-1:0]  a_q;
  logic [DATA_WIDTH-1:0]  b_q;

  logic                   x_neg;
  logic                   y_neg;
  logic [DATA_WIDTH-1:0]  x_mag;
  logic [DATA_WIDTH-1:0]  y_mag;
  logic [DATA_WIDTH:0]    rem_shift;
  logic [DATA_WIDTH:0]    trial;
  logic [DATA_WIDTH-1:0]  raw_res;

  // Operand magnitudes
  assign x_neg = x_i[DATA_WIDTH-1];
  assign y_neg = y_i[DATA_WIDTH-1];
  assign x_mag = x_neg ? (~x_i + 1'b1) : x_i;
  assign y_mag = y_neg ? (~y_i + 1'b1) : y_i;

  // Restoring division step
  assign rem_shift = {acc_q[DATA_WIDTH-1:0], a_q[DATA_WIDTH-1]};
  assign trial     = rem_shift - {1'b0, b_q};

  // Iterate one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rpn_pkg::MD_MUL;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DATA_WIDTH);
      op_q   <= req_i.op;
      acc_q  <= '0;
      if (req_i.op == rpn_pkg::MD_MUL) begin
        a_q   <= y_i;
        b_q   <= x_i;
        neg_q <= 1'b0;
      end else begin
        a_q   <= x_mag;
        b_q   <= y_mag;
        neg_q <= (req_i.op == rpn_pkg::MD_DIV) ? (x_neg ^ y_neg) : x_neg;
      end
    end else if (busy_q) begin
      if (op_q == rpn_pkg::MD_MUL) begin
        if (a_q[0]) begin
          acc_q <= {1'b0, acc_q[DATA_WIDTH-1:0] + b_q};
        end
        a_q <= a_q >> 1;
        b_q <= b_q << 1;
      end else if (!trial[DATA_WIDTH]) begin
        acc_q <= trial;
        a_q   <= {a_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        acc_q <= rem_shift;
        a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Select and sign-correct the result
  always_comb begin
    case (op_q)
      rpn_pkg::MD_DIV: raw_res = a_q;
      default:         raw_res = acc_q[DATA_WIDTH-1:0];
    endcase
  end

  assign res_o  = neg_q ? (~raw_res + 1'b1) : raw_res;
  assign done_o = done_q;

endmodule

// File: rtl/core/rpn_stack_machine.sv
// ----------------------------------------------------------------------------
// rpn_stack_machine
// Reverse-Polish stack machine: one instruction per input word, one status
// word (top of stack, depth, sticky error) per instruction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries action, opcode and
//   immediate. Every accepted word yields exactly one output word on
//   out_valid_o/out_ready_i with the top value, its valid flag, the depth
//   and the error code after the instruction.
//   The stack lives in a single-port-write memory with registered read; the
//   top entry is also kept in a register, so each instruction reads only the
//   second entry. An instruction is accepted in S_IDLE; the memory read
//   returns in S_EXEC, where the result is written back and registered
//   for output once the output register is free. mul, div and mod run
//   through the bit-serial multiply/divide unit in state S_MD first.
//   One instruction is in flight at a time; in_ready_o rises again as soon
//   as the result sits in the output register, even if it is not yet taken.
//   When the receiver stalls, the finished next result waits inside until
//   the output register frees.
//   Reset clears depth, error and the output valid; stack entries are not
//   cleared and need no clearing pass. Restart (action 1) clears depth and
//   error. After an error, instructions are ignored until restart.
// ----------------------------------------------------------------------------
module rpn_stack_machine #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [rpn_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic signed [rpn_pkg::VALUE_W-1:0]  immediate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rpn_pkg::VALUE_W-1:0]  top_value_o,
  output logic                                top_valid_o,
  output logic [rpn_pkg::DEPTH_F_W-1:0]       depth_o,
  output logic [rpn_pkg::ERROR_W-1:0]         error_code_o
);

  localparam int unsigned AW      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VAL_W   = rpn_pkg::VALUE_W;
  localparam int unsigned DFW     = rpn_pkg::DEPTH_F_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MD
  } state_e;

  state_e                       state_q;
  logic [DATA_WIDTH-1:0]        mem_q [STACK_DEPTH];
  logic [DATA_WIDTH-1:0]        rdata_q;
  logic                         act_q;
  logic [rpn_pkg::OPCODE_W-1:0] op_q;
  logic [DATA_WIDTH-1:0]        imm_q;
  logic [DEPTH_W-1:0]           depth_q;
  logic [DEPTH_W-1:0]           depth_d;
  rpn_pkg::err_e                err_q;
  rpn_pkg::err_e                err_d;
  logic [DATA_WIDTH-1:0]        top_q;
  logic [DATA_WIDTH-1:0]        top_d;
  logic                         out_valid_q;
  logic signed [VAL_W-1:0]      top_value_q;
  logic                         top_valid_q;
  logic [DFW-1:0]               depth_out_q;
  rpn_pkg::err_e                err_out_q;

  logic                         accept;
  logic                         out_free;
  logic                         commit;
  logic [AW-1:0]                raddr;
  logic                         mem_wr;
  logic [AW-1:0]                waddr;
  logic [DATA_WIDTH-1:0]        wdata;
  logic                         md_go;
  logic                         is_md_op;
  logic                         is_div_op;
  logic [DATA_WIDTH-1:0]        alu_res;
  logic [DATA_WIDTH-1:0]        md_res;
  logic                         md_done;
  logic [DATA_WIDTH-1:0]        res;
  rpn_pkg::md_req_t             md_req;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Second entry from the top; only used when depth is at least two
  assign raddr = AW'(depth_q - DEPTH_W'(2));

  assign is_div_op = (op_q == rpn_pkg::OP_DIV) || (op_q == rpn_pkg::OP_MOD);
  assign is_md_op  = is_div_op || (op_q == rpn_pkg::OP_MUL);

  rpn_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .op_i (op_q),
    .x_i  (rdata_q),
    .y_i  (top_q),
    .res_o(alu_res)
  );

  // Start the serial unit for mul, div and mod
  always_comb begin
    md_req.start = md_go;
    case (op_q)
      rpn_pkg::OP_DIV: md_req.op = rpn_pkg::MD_DIV;
      rpn_pkg::OP_MOD: md_req.op = rpn_pkg::MD_MOD;
      default:         md_req.op = rpn_pkg::MD_MUL;
    endcase
  end

  rpn_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (md_req),
    .x_i   (rdata_q),
    .y_i   (top_q),
    .done_o(md_done),
    .res_o (md_res)
  );

  assign res = (state_q == S_MD) ? md_res : alu_res;

  // Work out the next stack state and the write-back
  always_comb begin
    depth_d = depth_q;
    err_d   = err_q;
    top_d   = top_q;
    mem_wr  = 1'b0;
    waddr   = AW'(depth_q - 1'b1);
    wdata   = res;
    md_go   = 1'b0;
    if (act_q) begin
      depth_d = '0;
      err_d   = rpn_pkg::ERR_NONE;
    end else if (err_q == rpn_pkg::ERR_NONE) begin
      case (op_q) inside
        rpn_pkg::OP_PUSH: begin
          if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
            err_d = rpn_pkg::ERR_OVERFLOW;
          end else begin
            mem_wr  = 1'b1;
            waddr   = depth_q[AW-1:0];
            wdata   = imm_q;
            top_d   = imm_q;
            depth_d = depth_q + 1'b1;
          end
        end
        rpn_pkg::OP_NOT: begin
          if (depth_q == '0) begin
            err_d = rpn_pkg::ERR_UNDERFLOW;
          end else begin
            mem_wr = 1'b1;
            wdata  = ~top_q;
            top_d  = ~top_q;
          end
        end
        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
        rpn_pkg::OP_MOD, rpn_pkg::OP_SHL, rpn_pkg::OP_SAR, rpn_pkg::OP_AND,
        rpn_pkg::OP_OR, rpn_pkg::OP_XOR: begin
          if (depth_q < DEPTH_W'(2)) begin
            err_d = rpn_pkg::ERR_UNDERFLOW;
          end else if (is_div_op && (top_q == '0)) begin
            err_d = rpn_pkg::ERR_DIVZERO;
          end else begin
            md_go   = is_md_op && (state_q == S_EXEC);
            mem_wr  = 1'b1;
            waddr   = raddr;
            top_d   = res;
            depth_d = depth_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Commit once the result is final and the output register can take it
  assign commit = out_free && (((state_q == S_EXEC) && !md_go) ||
                               ((state_q == S_MD) && md_done));

  // Stack memory: read the second entry on accept, write back on commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem_q[raddr];
    end
    if (mem_wr && commit) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Latch the instruction word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      op_q  <= opcode_i;
      imm_q <= DATA_WIDTH'(immediate_i);
    end
  end

  // Sequencer, stack head and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      err_q       <= rpn_pkg::ERR_NONE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      top_value_q <= '0;
      top_valid_q <= 1'b0;
      depth_out_q <= '0;
      err_out_q   <= rpn_pkg::ERR_NONE;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q <= S_IDLE;
          end else if (md_go) begin
            state_q <= S_MD;
          end
        end
        S_MD: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (commit) begin
        depth_q     <= depth_d;
        err_q       <= err_d;
        top_q       <= top_d;
        top_value_q <= (depth_d != '0) ? VAL_W'($signed(top_d)) : '0;
        top_valid_q <= (depth_d != '0);
        depth_out_q <= DFW'(depth_d);
        err_out_q   <= err_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign top_value_o  = top_value_q;
  assign top_valid_o  = top_valid_q;
  assign depth_o      = depth_out_q;
  assign error_code_o = err_out_q;

endmodule

// File: rtl/core/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the RPN stack machine, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [31:0]  top_value_o,
  input logic                top_valid_o,
  input logic [8:0]          depth_o,
  input logic [1:0]          error_code_o
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o) &&
      $stable(top_valid_o) && $stable(depth_o) && $stable(error_code_o))
    else $error("output word changed while stalled");

  // One instruction in flight: ready drops after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an instruction is in flight");

  // Valid flag follows the depth
  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_valid_o == (depth_o != 9'd0)))
    else $error("top valid flag disagrees with depth");

  // Empty stack reports a zero top
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !top_valid_o |-> (top_value_o == 32'sd0))
    else $error("empty stack reports a nonzero top");

endmodule

bind rpn_stack_machine rpn_checker u_rpn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .top_value_o (top_value_o),
  .top_valid_o (top_valid_o),
  .depth_o     (depth_o),
  .error_code_o(error_code_o)
);

// File: sim/tb_rpn_stack_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_machine
// Self-checking bench for the RPN stack machine. A behavioral model of the
// stack tracks every accepted instruction word and predicts the status word
// it returns. Directed tasks cover the edge values of every operation and
// every error path, a fill test drives the stack to overflow, a
// back-pressure test stalls the output side, and a long random run mixes
// well-formed instruction streams with noise, random gaps and restarts.
// ----------------------------------------------------------------------------
module tb_rpn_stack_machine;

  localparam int unsigned STACK_N     = 256;
  localparam int unsigned W           = rpn_pkg::VALUE_W;
  localparam int unsigned OW          = rpn_pkg::OPCODE_W;
  localparam int unsigned RANDOM_N    = 400;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned END_WAIT    = 60;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned MAX_SHOWN   = 10;

  localparam logic ACT_EXEC    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic [rpn_pkg::VALUE_W-1:0]   top;
    logic                          valid;
    logic [rpn_pkg::DEPTH_F_W-1:0] depth;
    logic [rpn_pkg::ERROR_W-1:0]   err;
  } status_word_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          action_i;
  logic [OW-1:0]                 opcode_i;
  logic [rpn_pkg::VALUE_W-1:0]   immediate_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [rpn_pkg::VALUE_W-1:0]   top_value_o;
  logic                          top_valid_o;
  logic [rpn_pkg::DEPTH_F_W-1:0] depth_o;
  logic [rpn_pkg::ERROR_W-1:0]   error_code_o;

  // Model of the stack
  logic [W-1:0]  calc_stack [STACK_N];
  int unsigned   calc_depth;
  rpn_pkg::err_e calc_err;

  status_word_t status_q[$];
  int unsigned  fail_count;
  bit           gaps_on;
  int unsigned  rx_hold_len;

  rpn_stack_machine #(
    .STACK_DEPTH(STACK_N),
    .DATA_WIDTH (W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .opcode_i    (opcode_i),
    .immediate_i (immediate_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .top_value_o (top_value_o),
    .top_valid_o (top_valid_o),
    .depth_o     (depth_o),
    .error_code_o(error_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Edge values get a good share of the operands
  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return {1'b1, {(W-1){1'b0}}};
      4: return {1'b0, {(W-1){1'b1}}};
      5: return $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  // Any binary operation from add to xor
  function automatic logic [OW-1:0] pick_binop();
    return OW'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_XOR));
  endfunction

  function automatic logic [W-1:0] apply_op(logic [OW-1:0] op, logic [W-1:0] x,
                                            logic [W-1:0] y);
    logic [W-1:0] mx;
    logic [W-1:0] my;
    logic [W-1:0] q;
    mx = x[W-1] ? -x : x;
    my = y[W-1] ? -y : y;
    case (op)
      rpn_pkg::OP_ADD: return x + y;
      rpn_pkg::OP_SUB: return x - y;
      rpn_pkg::OP_MUL: return x * y;
      rpn_pkg::OP_DIV: begin
        q = mx / my;
        return (x[W-1] ^ y[W-1]) ? -q : q;
      end
      rpn_pkg::OP_MOD: begin
        q = mx % my;
        return x[W-1] ? -q : q;
      end
      rpn_pkg::OP_SHL: return (y >= W) ? '0 : x << y[4:0];
      rpn_pkg::OP_SAR: return (y >= W) ? {W{x[W-1]}} : W'($signed(x) >>> y[4:0]);
      rpn_pkg::OP_AND: return x & y;
      rpn_pkg::OP_OR:  return x | y;
      default: return x ^ y;
    endcase
  endfunction

  // Apply one accepted word to the model and queue the status it returns
  task automatic advance_model(input logic act, input logic [OW-1:0] op,
                               input logic [W-1:0] imm);
    logic [W-1:0] x;
    logic [W-1:0] y;
    status_word_t s;
    if (act == ACT_RESTART) begin
      calc_depth = 0;
      calc_err   = rpn_pkg::ERR_NONE;
    end else if (calc_err == rpn_pkg::ERR_NONE) begin
      case (op)
        rpn_pkg::OP_PUSH: begin
          if (calc_depth >= STACK_N) calc_err = rpn_pkg::ERR_OVERFLOW;
          else begin
            calc_stack[calc_depth] = imm;
            calc_depth++;
          end
        end
        rpn_pkg::OP_NOT: begin
          if (calc_depth < 1) calc_err = rpn_pkg::ERR_UNDERFLOW;
          else calc_stack[calc_depth-1] = ~calc_stack[calc_depth-1];
        end
        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
        rpn_pkg::OP_MOD, rpn_pkg::OP_SHL, rpn_pkg::OP_SAR, rpn_pkg::OP_AND,
        rpn_pkg::OP_OR, rpn_pkg::OP_XOR: begin
          if (calc_depth < 2) calc_err = rpn_pkg::ERR_UNDERFLOW;
          else begin
            x = calc_stack[calc_depth-2];
            y = calc_stack[calc_depth-1];
            if ((op == rpn_pkg::OP_DIV || op == rpn_pkg::OP_MOD) && y == '0) begin
              calc_err = rpn_pkg::ERR_DIVZERO;
            end else begin
              calc_stack[calc_depth-2] = apply_op(op, x, y);
              calc_depth--;
            end
          end
        end
        default: ;
      endcase
    end
    s.top   = (calc_depth >= 1) ? calc_stack[calc_depth-1] : '0;
    s.valid = (calc_depth != 0);
    s.depth = rpn_pkg::DEPTH_F_W'(calc_depth);
    s.err   = calc_err;
    status_q.push_back(s);
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Offer one word, hold it until taken, then maybe idle a while
  task automatic send_word(input logic act, input logic [OW-1:0] op,
                           input logic [W-1:0] imm);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    opcode_i    <= op;
    immediate_i <= imm;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    advance_model(act, op, imm);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_value(input logic [W-1:0] v);
    send_word(ACT_EXEC, rpn_pkg::OP_PUSH, v);
  endtask

  task automatic run_op(input logic [OW-1:0] op);
    send_word(ACT_EXEC, op, $urandom());
  endtask

  task automatic restart();
    send_word(ACT_RESTART, OW'($urandom_range(0, 15)), $urandom());
  endtask

  // Stop offering and wait for every predicted word
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  // Underflow on empty and short stacks, sticky error, restart
  task automatic test_errors();
    restart();
    run_op(rpn_pkg::OP_NOOP);
    run_op(rpn_pkg::OP_ADD);
    push_value(32'd5);
    restart();
    run_op(rpn_pkg::OP_NOT);
    restart();
    push_value(32'd9);
    run_op(rpn_pkg::OP_SUB);
    restart();
  endtask

  // Every operation with edge operands
  task automatic test_operations();
    push_value(32'h7FFF_FFFF);
    push_value(32'd1);
    run_op(rpn_pkg::OP_ADD);
    push_value('1);
    run_op(rpn_pkg::OP_DIV);
    push_value('1);
    run_op(rpn_pkg::OP_MOD);
    push_value(-32'sd7);
    push_value(32'd2);
    run_op(rpn_pkg::OP_MOD);
    push_value('0);
    run_op(rpn_pkg::OP_DIV);
    run_op(rpn_pkg::OP_PUSH + 4'd1);
    restart();
    push_value(32'h8000_0000);
    push_value(32'd31);
    run_op(rpn_pkg::OP_SAR);
    push_value(32'd40);
    run_op(rpn_pkg::OP_SAR);
    push_value(32'd32);
    run_op(rpn_pkg::OP_SHL);
    push_value(32'h5555_5555);
    run_op(rpn_pkg::OP_XOR);
    push_value(32'd4);
    run_op(rpn_pkg::OP_SHL);
    push_value(32'hFFFF_0000);
    run_op(rpn_pkg::OP_AND);
    push_value(32'h0000_000F);
    run_op(rpn_pkg::OP_OR);
    run_op(rpn_pkg::OP_NOT);
    push_value(32'hDEAD_BEEF);
    run_op(rpn_pkg::OP_MUL);
    push_value(32'd3);
    run_op(rpn_pkg::OP_SUB);
    run_op(rpn_pkg::OP_NOOP);
    run_op(rpn_pkg::OP_PUSH + 4'd2);
    run_op(rpn_pkg::OP_PUSH + 4'd3);
    restart();
  endtask

  // Fill the stack to the brim, then one push too many
  task automatic test_overflow();
    restart();
    repeat (STACK_N) push_value($urandom());
    run_op(rpn_pkg::OP_XOR);
    push_value($urandom());
    push_value($urandom());
    run_op(rpn_pkg::OP_NOT);
    restart();
  endtask

  // Long output stall while words keep coming, then a full drain
  task automatic test_backpressure();
    gaps_on     = 1'b0;
    rx_hold_len = HOLD_LEN;
    repeat (6) push_value(pick_value());
    repeat (5) run_op(pick_binop());
    wait_idle();
    gaps_on = 1'b1;
    restart();
  endtask

  // Mostly well-formed streams, some noise and broken sequences
  task automatic test_random();
    int unsigned   done;
    int unsigned   r;
    logic [OW-1:0] op;
    done = 0;
    while (done < RANDOM_N) begin
      if (done % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (calc_err != rpn_pkg::ERR_NONE) begin
        if (r < 80) begin
          restart();
          done++;
        end else begin
          send_word(ACT_EXEC, OW'($urandom_range(0, 15)), $urandom());
        end
      end else begin
        done++;
        if (r < 3) restart();
        else if (r < 8) send_word(ACT_EXEC, OW'($urandom_range(0, 15)), $urandom());
        else if (calc_depth < 2 && r < 90) push_value(pick_value());
        else if (calc_depth > 40 && r < 70) run_op(pick_binop());
        else if (r < 50) push_value(pick_value());
        else if (r < 88) run_op(pick_binop());
        else if (r < 94) run_op(rpn_pkg::OP_NOT);
        else begin
          op = (r < 97) ? rpn_pkg::OP_NOOP : rpn_pkg::OP_PUSH + OW'($urandom_range(1, 3));
          run_op(op);
        end
      end
    end
  endtask

  // Output side: random stalls, or a long hold when one is requested
  initial begin : drive_ready
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        stall_left  = rx_hold_len;
        rx_hold_len = 0;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each status word taken with the oldest prediction
  initial begin : check_status
    status_word_t got;
    status_word_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {top_value_o, top_valid_o, depth_o, error_code_o};
        if (status_q.size() == 0) begin
          report_failure($sformatf("unexpected word top=%h valid=%b depth=%0d err=%0d",
                                   got.top, got.valid, got.depth, got.err));
        end else begin
          want = status_q.pop_front();
          if (got.top !== want.top || got.valid !== want.valid ||
              got.depth !== want.depth || got.err !== want.err) begin
            report_failure($sformatf(
              "top=%h valid=%b depth=%0d err=%0d, expected top=%h valid=%b depth=%0d err=%0d",
              got.top, got.valid, got.depth, got.err,
              want.top, want.valid, want.depth, want.err));
          end
        end
      end
    end
  end

  // End the run when neither side moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run_tests
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_EXEC;
    opcode_i    = rpn_pkg::OP_NOOP;
    immediate_i = '0;
    gaps_on     = 1'b1;
    rx_hold_len = 0;
    fail_count  = 0;
    calc_depth  = 0;
    calc_err    = rpn_pkg::ERR_NONE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_errors();
    test_operations();
    test_overflow();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (END_WAIT) @(posedge clk_i);
    if (status_q.size() != 0) report_failure("status words missing at end of run");
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_alu.sv
rtl/core/rpn_muldiv.sv
rtl/core/rpn_stack_machine.sv
rtl/core/rpn_checker.sv
sim/tb_rpn_stack_machine.sv
